[hdl/pmc_pkg.sv]
`default_nettype none
package pmc_pkg;
    localparam int WAYS_DEF = 6;
    localparam int SET_BITS_DEF = 10;
    localparam logic [31:0] HASH_MULT = 32'h9E37_0001;
    localparam logic [4:0] COOKIE_MAX = 5'd16;
    localparam logic [3:0] IDX_BITS_RST = 4'd10;
    localparam logic [31:0] TIMEOUT_RST = 32'd3600000;
    localparam logic CFG_IDX_BITS = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;
    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] addr;
        logic [31:0] now;
        logic [15:0] mss;
        logic [4:0]  clen;
        logic [63:0] chi;
        logic [63:0] clo;
        logic        loss;
    } t_req;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] stamp;
        logic [15:0] mss;
        logic [9:0]  lcnt;
        logic [31:0] lloss;
        logic [4:0]  clen;
        logic [63:0] chi;
        logic [63:0] clo;
    } t_entry;

    function automatic logic tick_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction
endpackage
`default_nettype wire

[hdl/pmc_front.sv]
`default_nettype none
// Latches a request and computes its folded, hashed set index.
module pmc_front
    import pmc_pkg::*;
#(
    parameter int SET_BITS = SET_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire t_req                i_req,
    input  wire logic [3:0]          i_index_bits,
    input  wire logic                i_take,
    output logic                     o_valid,
    output t_req                     o_req,
    output logic [SET_BITS-1:0]      o_set
);
    logic        r_valid;
    t_req        r_req;
    logic [31:0] r_prod;
    logic [3:0]  w_b;
    logic [31:0] w_fold;
    logic [31:0] w_sh;

    assign w_fold = i_req.addr ^ (i_req.addr >> 24) ^ (i_req.addr >> 16)
                  ^ (i_req.addr >> 8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_start && !r_valid) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
        if (i_start && !r_valid) begin
            r_req  <= i_req;
            r_prod <= w_fold * HASH_MULT;
        end
    end

    always_comb begin
        w_b = i_index_bits;
        if (w_b == 4'd0) w_b = 4'd1;
        if (32'(w_b) > SET_BITS) w_b = 4'(SET_BITS);
        w_sh = r_prod >> (6'd32 - {2'b00, w_b});
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;
    assign o_set   = w_sh[SET_BITS-1:0];
endmodule
`default_nettype wire

[hdl/pmc_back.sv]
`default_nettype none
// Reads a whole set, chooses the way, writes back and forms the result.
// After reset the valid store is cleared one set per cycle.
module pmc_back
    import pmc_pkg::*;
#(
    parameter int WAYS     = WAYS_DEF,
    parameter int SET_BITS = SET_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire t_req                i_req,
    input  wire logic [SET_BITS-1:0] i_set,
    input  wire logic [31:0]         i_timeout,
    output logic                     o_take,
    output logic                     o_busy,
    output logic                     o_done,
    output logic                     o_hit,
    output t_entry                   o_ent
);
    localparam int SETS = 1 << SET_BITS;
    localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_WRITE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_entry mem [WAYS][SETS];
    logic vmem [WAYS][SETS];
    logic [SET_BITS-1:0] r_clr;
    t_entry r_rd [WAYS];
    logic [WAYS-1:0] r_rdv;
    t_req r_req;
    logic [SET_BITS-1:0] r_set;
    logic r_done, r_hit;
    t_entry r_out;

    logic w_found;
    logic [WB-1:0] w_fw, w_free, w_old, w_sel;
    logic w_hasfree;
    t_entry w_e, w_new, w_out;
    logic w_wen;

    always_comb begin
        w_found = 1'b0; w_fw = '0; w_hasfree = 1'b0; w_free = '0; w_old = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_rdv[w] && r_rd[w].tag == r_req.addr) begin
                w_found = 1'b1; w_fw = WB'(w);
            end
            if (!r_rdv[w]) begin
                w_hasfree = 1'b1; w_free = WB'(w);
            end
        end
        for (int w = 1; w < WAYS; w++)
            if (tick_before(r_rd[w].stamp, r_rd[w_old].stamp)) w_old = WB'(w);
        w_sel = w_found ? w_fw : (w_hasfree ? w_free : w_old);
        w_e = r_rd[w_fw];
        w_new = w_e;
        w_wen = 1'b0;
        if (w_found && tick_before(w_e.stamp + i_timeout, r_req.now)) begin
            w_new.stamp = r_req.now; w_wen = 1'b1;
        end
        if (r_req.op == OP_UPDATE) begin
            w_wen = 1'b1;
            if (!w_found) begin
                w_new = '0;
                w_new.tag = r_req.addr;
                w_new.stamp = r_req.now;
            end
            if (r_req.mss != 16'd0) w_new.mss = r_req.mss;
            if (r_req.clen != 5'd0) begin
                w_new.clen = (r_req.clen > COOKIE_MAX) ? COOKIE_MAX : r_req.clen;
                w_new.chi = r_req.chi;
                w_new.clo = r_req.clo;
            end
            if (r_req.loss) begin
                w_new.lcnt = w_new.lcnt + 10'd1;
                w_new.lloss = r_req.now;
            end else begin
                w_new.lcnt = 10'd0;
            end
        end
        w_out = '0;
        if (r_req.op == OP_QUERY && w_found) begin
            w_out = w_e;
            if (w_e.lcnt == 10'd0) w_out.lloss = 32'd0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == SET_BITS'(SETS - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_valid) n_state = S_READ;
            S_READ:  n_state = S_WRITE;
            S_WRITE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_WRITE);
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            for (int w = 0; w < WAYS; w++) vmem[w][r_clr] <= 1'b0;
        end
        if (r_state == S_IDLE && i_valid) begin
            r_req <= i_req;
            r_set <= i_set;
            for (int w = 0; w < WAYS; w++) begin
                r_rd[w]  <= mem[w][i_set];
                r_rdv[w] <= vmem[w][i_set];
            end
        end
        if (r_state == S_WRITE) begin
            if (w_wen) begin
                mem[w_sel][r_set]  <= w_new;
                vmem[w_sel][r_set] <= 1'b1;
            end
            r_hit <= w_found;
            r_out <= w_out;
        end
    end

    assign o_take = (r_state == S_IDLE) && i_valid;
    assign o_busy = (r_state != S_IDLE) || r_done;
    assign o_done = r_done;
    assign o_hit  = r_hit;
    assign o_ent  = r_out;
endmodule
`default_nettype wire

[hdl/peer_metrics_cache_top.sv]
`default_nettype none
// Peer metrics cache for IPv4 peers. A transaction is taken when start is
// high while busy is low; one result follows with o_done high for exactly
// one cycle, and the receiver cannot stall it. Each transaction is hashed
// and registered, its set is read, then the way is chosen and written back
// and the result registered; busy stays high until the result is shown, so
// one transaction is in flight at a time and a new one is taken only after
// the previous result has been shown. Valid bits live in a memory that is
// cleared one set per cycle after reset, all 2**SET_BITS sets (1024 by
// default), and busy is high throughout. Configuration writes go through
// i_cfg_we/i_cfg_idx/i_cfg_data and must only happen while the block is idle.
module peer_metrics_cache_top
    import pmc_pkg::*;
#(
    parameter int WAYS     = WAYS_DEF,
    parameter int SET_BITS = SET_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    output logic             o_done,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_op,
    input  wire logic [31:0] i_peer_addr,
    input  wire logic [31:0] i_now_time,
    input  wire logic [15:0] i_new_mss,
    input  wire logic [4:0]  i_new_cookie_len,
    input  wire logic [63:0] i_new_cookie_hi,
    input  wire logic [63:0] i_new_cookie_lo,
    input  wire logic        i_loss_seen,
    output logic             o_hit,
    output logic [15:0]      o_mss_out,
    output logic [4:0]       o_cookie_len_out,
    output logic [63:0]      o_cookie_hi_out,
    output logic [63:0]      o_cookie_lo_out,
    output logic [9:0]       o_loss_count,
    output logic [31:0]      o_last_loss_time
);
    logic [3:0]  r_index_bits;
    logic [31:0] r_timeout;
    t_req w_req, f_req;
    logic f_valid, b_take, b_busy;
    logic [SET_BITS-1:0] f_set;
    t_entry b_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= IDX_BITS_RST;
            r_timeout    <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_IDX_BITS) r_index_bits <= i_cfg_data[3:0];
            else r_timeout <= i_cfg_data;
        end
    end

    assign w_req = '{op: i_op, addr: i_peer_addr, now: i_now_time, mss: i_new_mss,
                     clen: i_new_cookie_len, chi: i_new_cookie_hi,
                     clo: i_new_cookie_lo, loss: i_loss_seen};

    // The front stage holds one request, loaded only while busy is low.
    pmc_front #(.SET_BITS(SET_BITS)) u_front (
        .i_clk, .i_rst_n, .i_start(start && !busy), .i_req(w_req),
        .i_index_bits(r_index_bits), .i_take(b_take),
        .o_valid(f_valid), .o_req(f_req), .o_set(f_set)
    );

    pmc_back #(.WAYS(WAYS), .SET_BITS(SET_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(f_valid), .i_req(f_req), .i_set(f_set),
        .i_timeout(r_timeout), .o_take(b_take), .o_busy(b_busy),
        .o_done, .o_hit, .o_ent(b_ent)
    );

    assign busy = f_valid || b_busy;
    assign o_mss_out = b_ent.mss;
    assign o_cookie_len_out = b_ent.clen;
    assign o_cookie_hi_out = b_ent.chi;
    assign o_cookie_lo_out = b_ent.clo;
    assign o_loss_count = b_ent.lcnt;
    assign o_last_loss_time = b_ent.lloss;
endmodule
`default_nettype wire

[dv/peer_metrics_cache_top_tb.sv]
`default_nettype none
module peer_metrics_cache_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pmc_pkg::*;

    localparam int WAYS = WAYS_DEF;
    localparam int SET_BITS = SET_BITS_DEF;
    localparam int DEPTH = WAYS << SET_BITS;
    // The block takes one transaction at a time and clears its valid store
    // after reset; the watchdog only counts cycles with no accepted transaction
    // or result, so this limit is generous.
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic        hit;
        logic [15:0] mss;
        logic [4:0]  clen;
        logic [63:0] chi;
        logic [63:0] clo;
        logic [9:0]  lcnt;
        logic [31:0] lloss;
    } t_metrics;

    // Metrics cache predictor plus the queue of expected results.
    class metrics_scoreboard;
        bit          valid_q[DEPTH];
        t_entry      store[DEPTH];
        logic [3:0]  idx_bits;
        logic [31:0] timeout;
        t_metrics    pending[$];
        int          mismatches;
        int          checked;
        int          hits;

        function void clear();
            foreach (valid_q[i]) valid_q[i] = 1'b0;
            idx_bits = IDX_BITS_RST;
            timeout = TIMEOUT_RST;
        endfunction

        function bit older(logic [31:0] a, logic [31:0] b);
            logic [31:0] d;
            d = a - b;
            return d[31];
        endfunction

        function int set_index(logic [31:0] a);
            int unsigned b;
            logic [31:0] f;
            b = idx_bits;
            if (b < 1) b = 1;
            if (b > SET_BITS) b = SET_BITS;
            f = a ^ (a >> 24) ^ (a >> 16) ^ (a >> 8);
            f = f * HASH_MULT;
            return int'(f >> (32 - b));
        endfunction

        // Records one accepted request and queues the result it must produce.
        function void note_request(t_req r);
            int base, found, freew, oldest, e;
            t_metrics m;
            base = set_index(r.addr) * WAYS;
            found = -1;
            freew = -1;
            oldest = -1;
            m = '0;
            for (int w = 0; w < WAYS; w++) begin
                e = base + w;
                if (valid_q[e]) begin
                    if (found < 0 && store[e].tag == r.addr) found = w;
                    if (oldest < 0 || older(store[e].stamp, store[base + oldest].stamp))
                        oldest = w;
                end else if (freew < 0) begin
                    freew = w;
                end
            end
            if (found >= 0) begin
                e = base + found;
                if (older(store[e].stamp + timeout, r.now)) store[e].stamp = r.now;
                m.hit = 1'b1;
                hits++;
            end
            if (r.op == OP_QUERY) begin
                if (found >= 0) begin
                    m.mss = store[e].mss;
                    m.clen = store[e].clen;
                    m.chi = store[e].chi;
                    m.clo = store[e].clo;
                    m.lcnt = store[e].lcnt;
                    m.lloss = (store[e].lcnt != 0) ? store[e].lloss : 32'd0;
                end
            end else begin
                if (found < 0) begin
                    e = base + ((freew >= 0) ? freew : oldest);
                    valid_q[e] = 1'b1;
                    store[e] = '0;
                    store[e].tag = r.addr;
                    store[e].stamp = r.now;
                end
                if (r.mss != 0) store[e].mss = r.mss;
                if (r.clen != 0) begin
                    store[e].clen = (r.clen > COOKIE_MAX) ? COOKIE_MAX : r.clen;
                    store[e].chi = r.chi;
                    store[e].clo = r.clo;
                end
                if (r.loss) begin
                    store[e].lcnt = store[e].lcnt + 10'd1;
                    store[e].lloss = r.now;
                end else begin
                    store[e].lcnt = '0;
                end
            end
            pending.push_back(m);
        endfunction

        function void check_result(t_metrics got);
            t_metrics exp;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: result with nothing expected: %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d mismatch\n  expected %p\n  actual   %p",
                             checked, exp, got);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        o_done;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_IDX_BITS;
    logic [31:0] i_cfg_data = '0;
    t_req        req = '0;
    t_metrics    res;

    always #5 i_clk = ~i_clk;

    peer_metrics_cache_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_done(o_done),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_op(req.op), .i_peer_addr(req.addr), .i_now_time(req.now),
        .i_new_mss(req.mss), .i_new_cookie_len(req.clen), .i_new_cookie_hi(req.chi),
        .i_new_cookie_lo(req.clo), .i_loss_seen(req.loss),
        .o_hit(res.hit), .o_mss_out(res.mss), .o_cookie_len_out(res.clen),
        .o_cookie_hi_out(res.chi), .o_cookie_lo_out(res.clo),
        .o_loss_count(res.lcnt), .o_last_loss_time(res.lloss)
    );

    metrics_scoreboard sb = new();
    int          idle_pct;
    int          idle_cycles;
    int          sent;
    logic [31:0] peers[$];
    logic [31:0] clock_ticks;

    // Results and accepted transactions are both observed at the rising edge,
    // so the predictor sees requests in the same order as the block.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_request(req);
            if (o_done) sb.check_result(res);
            if ((start && !busy) || o_done) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("peer_metrics_cache_top_tb NOT OK");
                $finish;
            end
        end
    end

    // Drives one request and holds it until the block takes it. Random idle
    // cycles are inserted before the request according to idle_pct. Start is
    // left high after acceptance; drain() or an idle insertion lowers it.
    task automatic send(t_req r);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sent++;
        @(negedge i_clk);
    endtask

    // Waits until every expected result is back, then lets the pipeline drain.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IDX_BITS) sb.idx_bits = value[3:0];
        else sb.timeout = value;
    endtask

    function automatic t_req random_req();
        t_req r;
        r.op = 1'($urandom_range(1));
        // Most addresses repeat from a small pool so that hits, updates of
        // existing entries and evictions in crowded sets are all common.
        if (peers.size() != 0 && $urandom_range(99) < 75)
            r.addr = peers[$urandom_range(peers.size() - 1)];
        else
            r.addr = $urandom();
        r.now = clock_ticks + $urandom_range(50);
        if ($urandom_range(9) == 0) r.now = $urandom();
        r.mss = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom());
        r.clen = ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom());
        r.chi = {$urandom(), $urandom()};
        r.clo = {$urandom(), $urandom()};
        r.loss = ($urandom_range(99) < 70);
        return r;
    endfunction

    task automatic random_phase(int count, int pct);
        t_req r;
        idle_pct = pct;
        for (int i = 0; i < count; i++) begin
            r = random_req();
            clock_ticks = r.now;
            send(r);
        end
    endtask

    initial begin
        t_req r;
        sb.clear();
        sent = 0;
        idle_pct = 0;
        clock_ticks = 32'd1000;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: miss on an empty cache, creation, hit, field extremes,
        // oversized cookie length, loss counting and clearing, and the time
        // comparison across the wrap point.
        r = '0;
        r.op = OP_QUERY;
        r.addr = 32'hFFFF_FFFF;
        send(r);
        r = '{op: OP_UPDATE, addr: 32'hFFFF_FFFF, now: 32'hFFFF_FFF0, mss: 16'hFFFF,
              clen: 5'd31, chi: '1, clo: '1, loss: 1'b1};
        send(r);
        r.op = OP_QUERY;
        send(r);
        r = '{op: OP_UPDATE, addr: 32'h0, now: 32'h7FFF_FFFF, mss: 16'd0, clen: 5'd16,
              chi: 64'h0123_4567_89AB_CDEF, clo: 64'hFEDC_BA98_7654_3210, loss: 1'b0};
        send(r);
        r.mss = 16'd1;
        r.clen = 5'd0;
        r.loss = 1'b1;
        send(r);
        r.loss = 1'b0;
        send(r);
        r.op = OP_QUERY;
        r.now = 32'h8000_0000;
        send(r);
        // Stale stamp: a hit far past the timeout refreshes the stamp.
        r.op = OP_QUERY;
        r.addr = 32'hFFFF_FFFF;
        r.now = 32'h0100_0000;
        send(r);

        // Tiny set index and timeout; updates to new peers force evictions.
        write_reg(CFG_IDX_BITS, 32'd1);
        write_reg(CFG_TIMEOUT, 32'd1);
        r = '0;
        for (int i = 0; i < 14; i++) begin
            r.op = OP_UPDATE;
            r.addr = 32'h0A00_0000 + i * 32'h0101_0101;
            r.now = 32'd2000 + ((i * 7) % 13);
            r.loss = i[0];
            r.mss = 16'(i);
            send(r);
        end
        r.op = OP_QUERY;
        r.addr = 32'h0A00_0000;
        send(r);

        // Loss counter wrap on a single peer at full rate.
        r = '0;
        r.op = OP_UPDATE;
        r.addr = 32'hC0A8_0001;
        r.loss = 1'b1;
        for (int i = 0; i < 1030; i++) begin
            r.now = 32'd5000 + i;
            send(r);
        end
        r.op = OP_QUERY;
        send(r);

        for (int i = 0; i < 24; i++) peers.push_back($urandom());

        // Random phases over several register settings and idling mixes.
        write_reg(CFG_IDX_BITS, 32'd0);
        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        random_phase(75, 0);
        write_reg(CFG_IDX_BITS, 32'd15);
        write_reg(CFG_TIMEOUT, 32'd20);
        random_phase(75, 66);
        drain();
        write_reg(CFG_IDX_BITS, 32'd3);
        write_reg(CFG_TIMEOUT, 32'd3600000);
        random_phase(75, 25);
        write_reg(CFG_IDX_BITS, 32'd2);
        write_reg(CFG_TIMEOUT, 32'd100);
        random_phase(75, 0);
        write_reg(CFG_IDX_BITS, 32'd10);
        random_phase(75, 66);
        write_reg(CFG_IDX_BITS, 32'd1);
        random_phase(75, 25);

        drain();
        $display("Sent %0d transactions, %0d results checked, %0d hits, over six",
                 sent, sb.checked, sb.hits);
        $display("index widths and five timeouts, with idle ratios of 0, 25 and 66%%.");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("peer_metrics_cache_top_tb OK");
        end else begin
            $display("Mismatches: %0d, results still expected: %0d",
                     sb.mismatches, sb.pending.size());
            $display("peer_metrics_cache_top_tb NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
